### sv/rcfp_pkg.sv
`timescale 1ns / 1ps

package rcfp_pkg;

  localparam int MAX_DIGITS_DEF = 4;
  localparam int CHAN_W = 14;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_START   = 8'h53; // 'S'
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_ARM     = 8'h44; // 'D'
  localparam logic [7:0] CH_DISARM  = 8'h64; // 'd'
  localparam logic [7:0] CH_CALIB   = 8'h47; // 'G'
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  localparam logic [CHAN_W-1:0] FIRST_OFFSET  = 14'd1000;
  localparam logic [CHAN_W-1:0] SECOND_OFFSET = 14'd2000;

  typedef enum logic [2:0] {
    KIND_OTHER  = 3'd0,
    KIND_ARM    = 3'd1,
    KIND_DISARM = 3'd2,
    KIND_CALIB  = 3'd3,
    KIND_TY     = 3'd4,
    KIND_RP     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ARM    = 3'd1,
    ACT_DISARM = 3'd2,
    ACT_CALIB  = 3'd3,
    ACT_YT     = 3'd4,
    ACT_RP     = 3'd5
  } action_t;

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_SECOND = 6'b000010,
    PH_WANT_X = 6'b000100,
    PH_X_DIG  = 6'b001000,
    PH_Y_DIG  = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_t;

endpackage

### sv/remote_command_frame_parser.sv
`timescale 1ns / 1ps

// Remote command frame parser. Takes one received byte per item, with the
// armed flag sampled alongside it, and returns exactly one result item per
// byte: most carry action none, the newline closing a good frame carries arm,
// disarm, calibrate or a channel pair. A new byte is taken every clock cycle
// while the result is not stalled; each byte passes through the input register
// and then the result register, with the frame state updated by one pass of logic between them. A NUL byte
// counts as no byte and still yields an action-none result.
module remote_command_frame_parser
  import rcfp_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_rx_byte,
  input  logic                     in_armed,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_action,
  output logic [CHAN_W-1:0]        out_first_channel,
  output logic signed [CHAN_W-1:0] out_second_channel
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_armed_r;

  // frame state
  logic              frame_open_r, frame_open_nxt;
  phase_t            phase_r, phase_nxt;
  kind_t             kind_r, kind_nxt;
  logic              frame_ok_r, frame_ok_nxt;
  logic [CHAN_W-1:0] x_r, x_nxt;
  logic [CHAN_W-1:0] y_r, y_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // result register
  logic                     out_valid_r;
  action_t                  act_r, act_nxt;
  logic [CHAN_W-1:0]        first_r, first_nxt;
  logic [CHAN_W-1:0]        second_r, second_nxt;

  logic              s1_go;
  logic              is_digit;
  logic              room;
  logic [CHAN_W-1:0] acc_in;
  logic [CHAN_W-1:0] acc_out;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign is_digit = (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);
  assign room     = cnt_r < CNT_W'(MAX_DIGITS);
  assign acc_in   = (phase_r == PH_Y_DIG) ? y_r : x_r;
  // acc * 10 + digit, kept to channel width
  assign acc_out  = (acc_in << 3) + (acc_in << 1) + {{(CHAN_W-4){1'b0}}, s1_byte_r[3:0]};

  always_comb begin
    frame_open_nxt = frame_open_r;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    frame_ok_nxt   = frame_ok_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    cnt_nxt        = cnt_r;
    act_nxt        = ACT_NONE;
    first_nxt      = '0;
    second_nxt     = '0;

    priority if (s1_byte_r == CH_NUL) begin
    end else if (s1_byte_r == CH_START) begin
      frame_open_nxt = 1'b1;
      phase_nxt      = PH_FIRST;
      kind_nxt       = KIND_OTHER;
      frame_ok_nxt   = 1'b1;
      x_nxt          = '0;
      y_nxt          = '0;
      cnt_nxt        = '0;
    end else if (!frame_open_r) begin
    end else if (s1_byte_r == CH_NL) begin
      if (phase_r != PH_FIRST) begin
        priority if (kind_r == KIND_ARM && !s1_armed_r) begin
          act_nxt = ACT_ARM;
        end else if (kind_r == KIND_DISARM && s1_armed_r) begin
          act_nxt = ACT_DISARM;
        end else if (kind_r == KIND_CALIB && !s1_armed_r) begin
          act_nxt = ACT_CALIB;
        end else if ((kind_r == KIND_TY || kind_r == KIND_RP) && frame_ok_r &&
                     phase_r == PH_Y_DIG && cnt_r != '0) begin
          act_nxt    = (kind_r == KIND_TY) ? ACT_YT : ACT_RP;
          first_nxt  = x_r + FIRST_OFFSET;
          second_nxt = SECOND_OFFSET - y_r;
        end else begin
        end
      end
      frame_open_nxt = 1'b0;
      phase_nxt      = PH_FIRST;
    end else begin
      unique case (phase_r)
        PH_FIRST: begin
          priority if (s1_byte_r == CH_ARM) begin
            kind_nxt = KIND_ARM;    phase_nxt = PH_IGNORE;
          end else if (s1_byte_r == CH_DISARM) begin
            kind_nxt = KIND_DISARM; phase_nxt = PH_IGNORE;
          end else if (s1_byte_r == CH_CALIB) begin
            kind_nxt = KIND_CALIB;  phase_nxt = PH_IGNORE;
          end else if (s1_byte_r == CH_T) begin
            kind_nxt = KIND_TY;     phase_nxt = PH_SECOND;
          end else if (s1_byte_r == CH_R) begin
            kind_nxt = KIND_RP;     phase_nxt = PH_SECOND;
          end else begin
            kind_nxt = KIND_OTHER;  frame_ok_nxt = 1'b0; phase_nxt = PH_IGNORE;
          end
        end
        PH_SECOND: begin
          if ((kind_r == KIND_TY && s1_byte_r == CH_Y) ||
              (kind_r == KIND_RP && s1_byte_r == CH_P)) begin
            phase_nxt = PH_WANT_X;
          end else begin
            frame_ok_nxt = 1'b0; phase_nxt = PH_IGNORE;
          end
        end
        PH_WANT_X: begin
          if (s1_byte_r == CH_X) begin
            phase_nxt = PH_X_DIG; cnt_nxt = '0;
          end else begin
            frame_ok_nxt = 1'b0; phase_nxt = PH_IGNORE;
          end
        end
        PH_X_DIG: begin
          priority if (is_digit && room) begin
            x_nxt = acc_out; cnt_nxt = cnt_r + 1'b1;
          end else if (s1_byte_r == CH_Y) begin
            phase_nxt = PH_Y_DIG; cnt_nxt = '0;
          end else begin
            // too many digits or a stray byte
            frame_ok_nxt = 1'b0; phase_nxt = PH_IGNORE;
          end
        end
        PH_Y_DIG: begin
          if (is_digit && room) begin
            y_nxt = acc_out; cnt_nxt = cnt_r + 1'b1;
          end else begin
            frame_ok_nxt = 1'b0; phase_nxt = PH_IGNORE;
          end
        end
        PH_IGNORE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      frame_open_r <= 1'b0;
      phase_r      <= PH_FIRST;
      kind_r       <= KIND_OTHER;
      frame_ok_r   <= 1'b1;
      x_r          <= '0;
      y_r          <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        out_valid_r  <= 1'b1;
        frame_open_r <= frame_open_nxt;
        phase_r      <= phase_nxt;
        kind_r       <= kind_nxt;
        frame_ok_r   <= frame_ok_nxt;
        x_r          <= x_nxt;
        y_r          <= y_nxt;
        cnt_r        <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_rx_byte;
      s1_armed_r <= in_armed;
    end
    if (s1_go) begin
      act_r    <= act_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = act_r;
  assign out_first_channel  = first_r;
  assign out_second_channel = second_r;

endmodule

### sim/remote_command_frame_parser_tb.sv
`timescale 1ns / 1ps

module remote_command_frame_parser_tb;
  import rcfp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    action_t                   action;
    logic [CHAN_W-1:0]         first;
    logic signed [CHAN_W-1:0]  second;
  } cmd_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_rx_byte = 8'h00;
  logic                     in_armed = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               out_action;
  logic [CHAN_W-1:0]        out_first_channel;
  logic signed [CHAN_W-1:0] out_second_channel;

  // frame tracking state, mirrors the parser
  bit                fr_open = 1'b0;
  phase_t            fr_phase = PH_FIRST;
  kind_t             fr_kind = KIND_OTHER;
  bit                fr_ok = 1'b1;
  logic [CHAN_W-1:0] x_acc = '0;
  logic [CHAN_W-1:0] y_acc = '0;
  int                n_digits = 0;

  cmd_result_t pending_results[$];
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          actions_seen[6];
  int          cycle_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold_left = 0;
  int          rx_wait = 0;

  remote_command_frame_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_armed           (in_armed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_first_channel  (out_first_channel),
    .out_second_channel (out_second_channel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_digit(inout logic [CHAN_W-1:0] acc, input logic [7:0] b);
    int v;
    if (n_digits < MAX_DIGITS_DEF) begin
      v = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
      acc = v[CHAN_W-1:0];
      n_digits++;
    end else begin
      fr_ok = 1'b0;
      fr_phase = PH_IGNORE;
    end
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // one result per byte; only a newline closing a good frame carries an action
  function automatic cmd_result_t decode_byte(logic [7:0] b, logic arm);
    cmd_result_t r;
    r.action = ACT_NONE;
    r.first  = '0;
    r.second = '0;
    if (b != CH_NUL) begin
      if (b == CH_START) begin
        fr_open  = 1'b1;
        fr_phase = PH_FIRST;
        fr_kind  = KIND_OTHER;
        fr_ok    = 1'b1;
        x_acc    = '0;
        y_acc    = '0;
        n_digits = 0;
      end else if (fr_open && b == CH_NL) begin
        if (fr_phase != PH_FIRST) begin
          if (fr_kind == KIND_ARM && !arm) begin
            r.action = ACT_ARM;
          end else if (fr_kind == KIND_DISARM && arm) begin
            r.action = ACT_DISARM;
          end else if (fr_kind == KIND_CALIB && !arm) begin
            r.action = ACT_CALIB;
          end else if ((fr_kind == KIND_TY || fr_kind == KIND_RP) && fr_ok &&
                       fr_phase == PH_Y_DIG && n_digits >= 1) begin
            r.action = (fr_kind == KIND_TY) ? ACT_YT : ACT_RP;
            r.first  = x_acc + FIRST_OFFSET;
            r.second = SECOND_OFFSET - y_acc;
          end
        end
        fr_open  = 1'b0;
        fr_phase = PH_FIRST;
      end else if (fr_open) begin
        case (fr_phase)
          PH_FIRST: begin
            if (b == CH_ARM) begin
              fr_kind = KIND_ARM; fr_phase = PH_IGNORE;
            end else if (b == CH_DISARM) begin
              fr_kind = KIND_DISARM; fr_phase = PH_IGNORE;
            end else if (b == CH_CALIB) begin
              fr_kind = KIND_CALIB; fr_phase = PH_IGNORE;
            end else if (b == CH_T) begin
              fr_kind = KIND_TY; fr_phase = PH_SECOND;
            end else if (b == CH_R) begin
              fr_kind = KIND_RP; fr_phase = PH_SECOND;
            end else begin
              fr_kind = KIND_OTHER; fr_ok = 1'b0; fr_phase = PH_IGNORE;
            end
          end
          PH_SECOND: begin
            if ((fr_kind == KIND_TY && b == CH_Y) || (fr_kind == KIND_RP && b == CH_P)) begin
              fr_phase = PH_WANT_X;
            end else begin
              fr_ok = 1'b0; fr_phase = PH_IGNORE;
            end
          end
          PH_WANT_X: begin
            if (b == CH_X) begin
              fr_phase = PH_X_DIG; n_digits = 0;
            end else begin
              fr_ok = 1'b0; fr_phase = PH_IGNORE;
            end
          end
          PH_X_DIG: begin
            if (is_digit(b)) begin
              add_digit(x_acc, b);
            end else if (b == CH_Y) begin
              fr_phase = PH_Y_DIG; n_digits = 0;
            end else begin
              fr_ok = 1'b0; fr_phase = PH_IGNORE;
            end
          end
          PH_Y_DIG: begin
            if (is_digit(b)) begin
              add_digit(y_acc, b);
            end else begin
              fr_ok = 1'b0; fr_phase = PH_IGNORE;
            end
          end
          default: begin
          end
        endcase
      end
    end
    return r;
  endfunction

  // valid is only lowered when a gap is actually taken
  task automatic send_byte(input logic [7:0] b, input logic arm);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_armed   <= arm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(decode_byte(b, arm));
    bytes_sent++;
  endtask

  // occasionally slips a nul in front, which must change nothing
  task automatic send_cmd_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) send_byte(CH_NUL, 1'($urandom_range(0, 1)));
    send_byte(b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(input string s, input logic arm);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], arm);
  endtask

  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_cmd_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly well-formed channel commands, some with one defect
  task automatic send_channel_frame();
    int  flaw;
    bit  is_ty;
    flaw  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 7) : -1;
    is_ty = 1'($urandom_range(0, 1));
    send_cmd_byte(CH_START);
    send_cmd_byte(is_ty ? CH_T : CH_R);
    if (flaw == 7) send_cmd_byte(is_ty ? CH_P : CH_Y);
    else send_cmd_byte(is_ty ? CH_Y : CH_P);
    send_cmd_byte(CH_X);
    send_digits(flaw == 0 ? 5 : $urandom_range(0, 4));
    if (flaw == 5) send_cmd_byte(CH_START);
    if (flaw != 1) send_cmd_byte(CH_Y);
    send_digits(flaw == 2 ? 0 : (flaw == 3 ? 5 : $urandom_range(1, 4)));
    if (flaw == 4) send_cmd_byte(8'($urandom_range(1, 255)));
    if (flaw != 6) send_cmd_byte(CH_NL);
  endtask

  task automatic send_mode_frame();
    int sel;
    int n_tail;
    sel    = $urandom_range(0, 2);
    n_tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    send_cmd_byte(CH_START);
    send_cmd_byte(sel == 0 ? CH_ARM : (sel == 1 ? CH_DISARM : CH_CALIB));
    for (int i = 0; i < n_tail; i++) send_cmd_byte(8'($urandom_range(1, 255)));
    send_cmd_byte(CH_NL);
  endtask

  task automatic send_junk(input bit framed);
    int n;
    n = $urandom_range(1, 6);
    if (framed) send_cmd_byte(CH_START);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_cmd_byte(CH_NL);
  endtask

  task automatic test_mode_commands();
    send_text("SD\n", 1'b0);
    send_text("Sd\n", 1'b1);
    send_text("SGz\n", 1'b0);
    // arm while already armed falls through to the channel check and fails
    send_text("SD\n", 1'b1);
    wait_drained();
  endtask

  task automatic test_channel_extremes();
    send_text("SRPXY0\n", 1'b0);
    send_text("STYX9999Y9999\n", 1'b1);
    wait_drained();
  endtask

  task automatic test_edge_bytes();
    send_byte(CH_NUL, 1'b1);
    send_byte(CH_NL, 1'b0);
    send_text("S\n", 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    rx_hold_left = 300;
    repeat (6) send_channel_frame();
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_stream(input int n_bytes, input bit tx_idle, input bit rx_idle);
    int goal;
    int pick;
    goal       = bytes_sent + n_bytes;
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    while (bytes_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_channel_frame();
      else if (pick < 75) send_mode_frame();
      else if (pick < 90) send_junk(1'b1);
      else send_junk(1'b0);
    end
    wait_drained();
  endtask

  // receiver side: random stalls plus the long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on) rx_wait = pick_gap();
    end
  end

  always @(posedge clk) begin
    cmd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: action %0d", out_action);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_action);
          mismatch_count++;
        end
        if (out_first_channel !== want.first) begin
          $error("first_channel: expected %0d, got %0d", want.first, out_first_channel);
          mismatch_count++;
        end
        if (out_second_channel !== want.second) begin
          $error("second_channel: expected %0d, got %0d", want.second, out_second_channel);
          mismatch_count++;
        end
        if (out_action < 3'd6) actions_seen[out_action]++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL remote_command_frame_parser");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mode_commands();
    test_channel_extremes();
    test_edge_bytes();
    test_backpressure();
    test_random_stream(250, 1'b1, 1'b1);
    test_random_stream(225, 1'b0, 1'b0);
    test_random_stream(225, 1'b1, 1'b0);
    test_random_stream(225, 1'b0, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes and %0d results over %0d cycles", bytes_sent, results_seen,
             cycle_count);
    $display("actions: arm %0d, disarm %0d, calibrate %0d, yaw/throttle %0d, roll/pitch %0d",
             actions_seen[ACT_ARM], actions_seen[ACT_DISARM], actions_seen[ACT_CALIB],
             actions_seen[ACT_YT], actions_seen[ACT_RP]);
    if (mismatch_count == 0) begin
      $display("PASS remote_command_frame_parser");
    end else begin
      $display("FAIL remote_command_frame_parser");
    end
    $finish;
  end

endmodule
